FILE: src/uart_dollar_line_framer_macros.svh
// ---------------------------------------------------------------------------
// uart dollar line framer assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ---------------------------------------------------------------------------
`ifndef UART_DOLLAR_LINE_FRAMER_MACROS_SVH
`define UART_DOLLAR_LINE_FRAMER_MACROS_SVH

// same-cycle implication
`define UDLF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UDLF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/udlf_pkg.sv
// ---------------------------------------------------------------------------
// udlf_pkg
// request codes, character constants and beat structs of the line framer
// ---------------------------------------------------------------------------
package udlf_pkg;

    localparam int HOST_INDEX_W  = 6;
    localparam int LINE_LENGTH_W = 7;

    localparam logic [7:0] CHAR_CR     = 8'h0d;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;

    typedef enum logic [1:0] {
        REQ_RX  = 2'd0,
        REQ_TX  = 2'd1,
        REQ_HWR = 2'd2,
        REQ_HRD = 2'd3
    } req_t;

    typedef struct packed {
        req_t                    req_type;
        logic [7:0]              rx_byte;
        logic [HOST_INDEX_W-1:0] host_index;
        logic [7:0]              host_data;
    } item_t;

    // item held in the execute stage, with the host index range check done
    typedef struct packed {
        item_t item;
        logic  host_ok;
    } stage_t;

    typedef struct packed {
        logic                     tx_valid;
        logic [7:0]               tx_byte;
        logic [7:0]               read_data;
        logic                     message_ready;
        logic [LINE_LENGTH_W-1:0] line_length;
        logic                     receive_enabled;
        logic                     end_wait;
    } result_t;

endpackage

FILE: src/udlf_line_ram.sv
// ---------------------------------------------------------------------------
// udlf_line_ram
// line buffer, one write port and one read port with registered read data
// ---------------------------------------------------------------------------
module udlf_line_ram #(
    parameter int LINE_DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(LINE_DEPTH)-1:0] wr_addr,
    input  logic [7:0]                    wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(LINE_DEPTH)-1:0] rd_addr,
    output logic [7:0]                    rd_data
);

    logic [7:0] mem [LINE_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/udlf_exec.sv
// ---------------------------------------------------------------------------
// udlf_exec
// framer state registers and per-beat update, driven by buffer read data
// ---------------------------------------------------------------------------
`include "uart_dollar_line_framer_macros.svh"

module udlf_exec #(
    parameter int LINE_DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  udlf_pkg::stage_t              stage,
    input  logic [7:0]                    rd_data,
    output logic [$clog2(LINE_DEPTH)-1:0] tx_index_next,
    output logic                          wr_en,
    output logic [$clog2(LINE_DEPTH)-1:0] wr_addr,
    output logic [7:0]                    wr_data,
    output udlf_pkg::result_t             result
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = $clog2(LINE_DEPTH + 1);

    logic [CW-1:0] rx_count_reg;
    logic [CW-1:0] rx_count_next;
    logic [AW-1:0] tx_index_reg;
    logic          end_wait_reg;
    logic          end_wait_next;
    logic          ready_reg;
    logic          ready_next;
    logic          rx_en_reg;
    logic          rx_en_next;
    logic [CW-1:0] base_cnt;
    logic [7:0]    rx_b;
    logic [7:0]    rd_out;
    logic          tx_valid;
    logic [7:0]    tx_byte;

    assign rx_b = stage.item.rx_byte;

    always_comb
    begin
        rx_count_next = rx_count_reg;
        tx_index_next = tx_index_reg;
        end_wait_next = end_wait_reg;
        ready_next    = ready_reg;
        rx_en_next    = rx_en_reg;
        base_cnt      = (rx_b == udlf_pkg::CHAR_DOLLAR) ? '0 : rx_count_reg;
        wr_en         = 1'b0;
        wr_addr       = base_cnt[AW-1:0];
        wr_data       = rx_b;
        rd_out        = 8'd0;
        tx_valid      = 1'b0;
        tx_byte       = 8'd0;
        if (fire)
        begin
            case (stage.item.req_type)
                udlf_pkg::REQ_RX:
                begin
                    if (rx_en_reg)
                    begin
                        if (end_wait_reg)
                        begin
                            if (rx_b == udlf_pkg::CHAR_CR)
                            begin
                                end_wait_next = 1'b0;
                                rx_count_next = '0;
                                tx_index_next = '0;
                            end
                        end
                        else if (!(rx_count_reg == '0 && rx_b != udlf_pkg::CHAR_DOLLAR))
                        begin
                            if (base_cnt >= CW'(LINE_DEPTH))
                            begin
                                // full line: drop the byte and start over
                                rx_count_next = '0;
                            end
                            else if (rx_b != udlf_pkg::CHAR_CR)
                            begin
                                wr_en         = 1'b1;
                                rx_count_next = CW'(base_cnt + 1'b1);
                            end
                            else
                            begin
                                ready_next = 1'b1;
                                rx_en_next = 1'b0;
                            end
                        end
                    end
                end
                udlf_pkg::REQ_TX:
                begin
                    tx_valid = 1'b1;
                    tx_byte  = rd_data;
                    if (rd_data == udlf_pkg::CHAR_CR)
                    begin
                        rx_en_next    = 1'b1;
                        ready_next    = 1'b0;
                        end_wait_next = 1'b1;
                    end
                    tx_index_next = (tx_index_reg == AW'(LINE_DEPTH - 1)) ? '0
                                  : AW'(tx_index_reg + 1'b1);
                end
                udlf_pkg::REQ_HWR:
                begin
                    if (stage.host_ok)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(stage.item.host_index);
                        wr_data = stage.item.host_data;
                    end
                end
                udlf_pkg::REQ_HRD:
                begin
                    if (stage.host_ok)
                    begin
                        rd_out = rd_data;
                    end
                end
                default:
                begin
                    rd_out = 8'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_count_reg <= '0;
            tx_index_reg <= '0;
            end_wait_reg <= 1'b0;
            ready_reg    <= 1'b0;
            rx_en_reg    <= 1'b1;
        end
        else
        begin
            rx_count_reg <= rx_count_next;
            tx_index_reg <= tx_index_next;
            end_wait_reg <= end_wait_next;
            ready_reg    <= ready_next;
            rx_en_reg    <= rx_en_next;
        end
    end

    always_comb
    begin
        result.tx_valid        = tx_valid;
        result.tx_byte         = tx_byte;
        result.read_data       = rd_out;
        result.message_ready   = ready_next;
        result.line_length     = udlf_pkg::LINE_LENGTH_W'(rx_count_next);
        result.receive_enabled = rx_en_next;
        result.end_wait        = end_wait_next;
    end

    `UDLF_ASSERT_NOW(a_ready_blocks_rx, ready_reg, !rx_en_reg, "message ready with receive on")
    `UDLF_ASSERT_NOW(a_end_wait_rx_on, end_wait_reg, rx_en_reg, "end wait with receive off")
    `UDLF_ASSERT_NOW(a_count_range, 1'b1, rx_count_reg <= CW'(LINE_DEPTH), "line count overrun")

endmodule

FILE: src/uart_dollar_line_framer.sv
// ---------------------------------------------------------------------------
// uart_dollar_line_framer
// dollar-framed line receiver and replier over one shared line buffer
// ---------------------------------------------------------------------------
// order: a taken beat passes the buffer read register, then the update into
//   the output register, before its result beat is offered
// throughput: one beat per cycle unless the output is stalled, set by the single
//   buffer read port; the buffer read is launched as the beat is taken, a
//   write-to-read forward register covers a read of the entry written in that same cycle
// reset: counters and flags clear, receive enabled; buffer contents stay
//   undefined until written, no clearing pass
`include "uart_dollar_line_framer_macros.svh"

module uart_dollar_line_framer #(
    parameter int LINE_DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] req_type,
    input  logic [7:0] rx_byte,
    input  logic [5:0] host_index,
    input  logic [7:0] host_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       tx_valid,
    output logic [7:0] tx_byte,
    output logic [7:0] read_data,
    output logic       message_ready,
    output logic [6:0] line_length,
    output logic       receive_enabled,
    output logic       end_wait
);

    localparam int AW = $clog2(LINE_DEPTH);

    // execute stage: the beat whose buffer read is in flight
    logic                s1_valid_reg;
    logic                s1_valid_next;
    udlf_pkg::stage_t    s1_stage_reg;
    udlf_pkg::stage_t    in_stage;
    logic                s1_is_tx;

    // forward of a write that hit the address read in the same cycle
    logic                fwd_hit_reg;
    logic [7:0]          fwd_data_reg;
    logic                fwd_hit_now;

    // output register
    logic                out_valid_reg;
    udlf_pkg::result_t   out_result_reg;

    logic                accept;
    logic                exec_fire;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       tx_index_next;
    logic [7:0]          mem_q;
    logic [7:0]          exec_rd_data;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [7:0]          wr_data;
    udlf_pkg::result_t   exec_result;

    // a held beat executes once the output register is free or draining
    assign exec_fire = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || exec_fire;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        in_stage.item.req_type   = udlf_pkg::req_t'(req_type);
        in_stage.item.rx_byte    = rx_byte;
        in_stage.item.host_index = host_index;
        in_stage.item.host_data  = host_data;
        in_stage.host_ok         = int'(host_index) < LINE_DEPTH;
    end

    // transmit reads follow the index as left by the beat now executing
    assign rd_addr = (udlf_pkg::req_t'(req_type) == udlf_pkg::REQ_TX) ? tx_index_next
                   : AW'(host_index);

    assign fwd_hit_now  = wr_en && (wr_addr == rd_addr);
    assign exec_rd_data = fwd_hit_reg ? fwd_data_reg : mem_q;
    assign s1_is_tx     = s1_stage_reg.item.req_type == udlf_pkg::REQ_TX;

    udlf_line_ram #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (mem_q)
    );

    udlf_exec #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_exec (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (exec_fire),
        .stage         (s1_stage_reg),
        .rd_data       (exec_rd_data),
        .tx_index_next (tx_index_next),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .result        (exec_result)
    );

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (exec_fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                fwd_hit_reg <= fwd_hit_now;
            end
            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_stage_reg <= in_stage;
            fwd_data_reg <= wr_data;
        end
        if (exec_fire)
        begin
            out_result_reg <= exec_result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign tx_valid        = out_result_reg.tx_valid;
    assign tx_byte         = out_result_reg.tx_byte;
    assign read_data       = out_result_reg.read_data;
    assign message_ready   = out_result_reg.message_ready;
    assign line_length     = out_result_reg.line_length;
    assign receive_enabled = out_result_reg.receive_enabled;
    assign end_wait        = out_result_reg.end_wait;

    `UDLF_ASSERT_NEXT(a_fire_delivers, exec_fire, out_valid_reg, "executed beat not offered")
    `UDLF_ASSERT_NEXT(a_fwd_capture, accept && fwd_hit_now, fwd_hit_reg, "write forward missed")
    `UDLF_ASSERT_NEXT(a_tx_result, exec_fire && s1_is_tx, out_result_reg.tx_valid, "tx beat lost")

endmodule

FILE: tb/sv/uart_dollar_line_framer_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uart_dollar_line_framer_tb
// self-checking bench for the dollar line framer: request beats go in with
// bursty timing, a behavioral copy of the framer predicts every result beat,
// and a monitor compares each result beat field by field in order
// ---------------------------------------------------------------------------
module uart_dollar_line_framer_tb;

    localparam int    LINE_DEPTH   = 64;
    localparam int    ITEM_TARGET  = 1950;
    localparam int    LONG_HOLD    = 300;
    localparam int    DRAIN_LIMIT  = 5000;
    localparam longint TIMEOUT_NS  = 5_000_000;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n;

    always #5 clk = ~clk;

    // request side
    logic       in_valid;
    logic       in_ready;
    logic [1:0] req_type;
    logic [7:0] rx_byte;
    logic [5:0] host_index;
    logic [7:0] host_data;

    // result side
    logic       out_valid;
    logic       out_ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [7:0] read_data;
    logic       message_ready;
    logic [6:0] line_length;
    logic       receive_enabled;
    logic       end_wait;

    uart_dollar_line_framer #(
        .LINE_DEPTH(LINE_DEPTH)
    ) dut (
        .*
    );

    // behavioral copy of the framer state
    logic [7:0] line_mem [LINE_DEPTH];
    bit         line_set [LINE_DEPTH];     // entry written at least once
    logic [6:0] rx_cnt      = '0;
    logic [5:0] tx_ptr      = '0;
    logic       end_wait_st = 1'b0;
    logic       ready_st    = 1'b0;
    logic       rx_on       = 1'b1;

    udlf_pkg::result_t predicted_outputs [$];

    int mismatches   = 0;
    int beats_sent   = 0;
    int burst_left   = 0;
    int holds_wanted = 0;   // raised by the stimulus side only
    int holds_done   = 0;   // raised by the drain side only

    // -----------------------------------------------------------------------
    // prediction: apply one accepted request beat, return its result beat
    // -----------------------------------------------------------------------
    function automatic udlf_pkg::result_t predict_framer(udlf_pkg::item_t it);
        udlf_pkg::result_t r;
        logic [7:0]        b;
        r = '0;
        b = it.rx_byte;
        case (it.req_type)
            udlf_pkg::REQ_RX:
            begin
                // receive off: byte ignored entirely
                if (rx_on && end_wait_st)
                begin
                    // end-wait only listens for a carriage return
                    if (b == udlf_pkg::CHAR_CR)
                    begin
                        end_wait_st = 1'b0;
                        rx_cnt      = '0;
                        tx_ptr      = '0;
                    end
                end
                else if (rx_on && (rx_cnt != 0 || b == udlf_pkg::CHAR_DOLLAR))
                begin
                    // a dollar always restarts the line at entry zero
                    if (b == udlf_pkg::CHAR_DOLLAR)
                        rx_cnt = '0;
                    if (rx_cnt >= LINE_DEPTH)
                        rx_cnt = '0;            // full line: byte dropped, count cleared
                    else if (b != udlf_pkg::CHAR_CR)
                    begin
                        line_mem[rx_cnt] = b;
                        line_set[rx_cnt] = 1'b1;
                        rx_cnt           = rx_cnt + 1'b1;
                    end
                    else
                    begin
                        ready_st = 1'b1;
                        rx_on    = 1'b0;
                    end
                end
            end
            udlf_pkg::REQ_TX:
            begin
                r.tx_valid = 1'b1;
                r.tx_byte  = line_mem[tx_ptr];
                // sending the carriage return ends the reply
                if (r.tx_byte == udlf_pkg::CHAR_CR)
                begin
                    rx_on       = 1'b1;
                    ready_st    = 1'b0;
                    end_wait_st = 1'b1;
                end
                tx_ptr = tx_ptr + 1'b1;         // wraps at the line depth
            end
            // a 6-bit host index never reaches the line depth here
            udlf_pkg::REQ_HWR:
            begin
                line_mem[it.host_index] = it.host_data;
                line_set[it.host_index] = 1'b1;
            end
            default:
                r.read_data = line_mem[it.host_index];
        endcase
        r.message_ready   = ready_st;
        r.line_length     = rx_cnt;
        r.receive_enabled = rx_on;
        r.end_wait        = end_wait_st;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
        mismatches++;
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == udlf_pkg::CHAR_CR || b == udlf_pkg::CHAR_DOLLAR);
        return b;
    endfunction

    // -----------------------------------------------------------------------
    // request driver: bursts of beats with random gaps between bursts
    // -----------------------------------------------------------------------
    task automatic send_beat(input udlf_pkg::item_t it);
        int gap;
        if (burst_left == 0)
        begin
            // idle gap, with junk on the payload while valid is low
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
            in_valid   <= 1'b0;
            req_type   <= 2'($urandom);
            rx_byte    <= 8'($urandom);
            host_index <= 6'($urandom);
            host_data  <= 8'($urandom);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        in_valid   <= 1'b1;
        req_type   <= it.req_type;
        rx_byte    <= it.rx_byte;
        host_index <= it.host_index;
        host_data  <= it.host_data;
        do
            @(posedge clk);
        while (!in_ready);
        // beat taken at this edge: predict before the next one is chosen
        predicted_outputs.push_back(predict_framer(it));
        beats_sent++;
    endtask

    // request builders, fields the request does not use get random values
    task automatic rx(input logic [7:0] b);
        udlf_pkg::item_t it;
        it.req_type   = udlf_pkg::REQ_RX;
        it.rx_byte    = b;
        it.host_index = 6'($urandom);
        it.host_data  = 8'($urandom);
        send_beat(it);
    endtask

    task automatic host_write(input logic [5:0] idx, input logic [7:0] d);
        udlf_pkg::item_t it;
        it.req_type   = udlf_pkg::REQ_HWR;
        it.rx_byte    = 8'($urandom);
        it.host_index = idx;
        it.host_data  = d;
        send_beat(it);
    endtask

    task automatic host_read(input logic [5:0] idx);
        udlf_pkg::item_t it;
        // never read an entry that holds nothing yet
        if (!line_set[idx])
            host_write(idx, 8'($urandom));
        it.req_type   = udlf_pkg::REQ_HRD;
        it.rx_byte    = 8'($urandom);
        it.host_index = idx;
        it.host_data  = 8'($urandom);
        send_beat(it);
    endtask

    task automatic tx();
        udlf_pkg::item_t it;
        // never transmit an entry that holds nothing yet
        if (!line_set[tx_ptr])
            host_write(tx_ptr, 8'($urandom));
        it.req_type   = udlf_pkg::REQ_TX;
        it.rx_byte    = 8'($urandom);
        it.host_index = 6'($urandom);
        it.host_data  = 8'($urandom);
        send_beat(it);
    endtask

    // bring the framer back to receive on, no end-wait
    task automatic settle_receiver();
        while (!rx_on)
        begin
            host_write(tx_ptr, udlf_pkg::CHAR_CR);
            tx();
        end
        if (end_wait_st)
            rx(udlf_pkg::CHAR_CR);
    endtask

    // one well-formed exchange: framed line in, host look-up, reply out
    task automatic run_line_exchange();
        int         len;
        int         n;
        int         i;
        logic [7:0] b;
        settle_receiver();
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 20);
        if ($urandom_range(0, 3) == 0)
            rx(plain_byte());                   // stray byte before the frame
        rx(udlf_pkg::CHAR_DOLLAR);
        for (i = 0; i < len; i++)
        begin
            b = ($urandom_range(0, 40) == 0) ? udlf_pkg::CHAR_DOLLAR : plain_byte();
            rx(b);
        end
        rx(udlf_pkg::CHAR_CR);
        if (ready_st)
        begin
            n = $urandom_range(0, 4);
            for (i = 0; i < n; i++)
                host_read(6'($urandom_range(0, rx_cnt - 1)));
            if ($urandom_range(0, 2) == 0)
                rx(8'($urandom));               // receive is off, dropped
            n = $urandom_range(1, 12);
            for (i = 0; i < n; i++)
                host_write(tx_ptr + 6'(i), (i == n - 1) ? udlf_pkg::CHAR_CR : plain_byte());
            for (i = 0; i < n; i++)
                tx();
            if ($urandom_range(0, 2) == 0)
                rx(plain_byte());               // end-wait ignores it
            rx(udlf_pkg::CHAR_CR);
        end
    endtask

    // -----------------------------------------------------------------------
    // tests
    // -----------------------------------------------------------------------
    task automatic test_directed_frame();
        rx(8'h41);                      // no line open: ignored
        rx(udlf_pkg::CHAR_DOLLAR);
        rx(8'h00);
        rx(8'hff);
        rx(udlf_pkg::CHAR_DOLLAR);      // restart at entry zero
        rx(8'h41);
        rx(udlf_pkg::CHAR_CR);          // message ready, receive off
        rx(udlf_pkg::CHAR_DOLLAR);      // receive off: ignored
        host_read(6'd0);
        host_read(6'd1);
        host_write(6'd63, 8'hff);
        host_read(6'd63);
        host_write(6'd0, 8'h00);
        host_write(6'd1, udlf_pkg::CHAR_CR);
        host_read(6'd0);
        tx();
        tx();                           // carriage return out: receive on, end-wait
        rx(udlf_pkg::CHAR_DOLLAR);      // end-wait: ignored
        rx(udlf_pkg::CHAR_CR);          // end-wait left, counters cleared
    endtask

    task automatic test_overflow();
        int i;
        settle_receiver();
        // full line, then a carriage return is dropped and clears the count
        rx(udlf_pkg::CHAR_DOLLAR);
        for (i = 1; i < LINE_DEPTH; i++)
            rx(plain_byte());
        rx(udlf_pkg::CHAR_CR);
        // full line, then a dollar still restarts it
        rx(udlf_pkg::CHAR_DOLLAR);
        for (i = 1; i < LINE_DEPTH; i++)
            rx(plain_byte());
        rx(udlf_pkg::CHAR_DOLLAR);
        rx(udlf_pkg::CHAR_CR);
    endtask

    task automatic test_transmit_wrap();
        int i;
        for (i = 0; i < LINE_DEPTH; i++)
            host_write(6'(i), plain_byte());
        // no carriage return in the buffer, so the index runs past the end
        for (i = 0; i < LINE_DEPTH + 6; i++)
            tx();
    endtask

    task automatic test_backpressure();
        // long receiver hold while the sender keeps offering beats
        holds_wanted++;
        burst_left = 200;
        run_line_exchange();
        run_line_exchange();
    endtask

    task automatic test_random_traffic();
        int i;
        while (beats_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                // noise: any request with any fields
                for (i = $urandom_range(1, 8); i > 0; i--)
                    case ($urandom_range(0, 3))
                        0:       rx(8'($urandom));
                        1:       tx();
                        2:       host_write(6'($urandom), 8'($urandom));
                        default: host_read(6'($urandom));
                    endcase
            end
            else
                run_line_exchange();
        end
    endtask

    // -----------------------------------------------------------------------
    // result side: receiver stall patterns, plus the long hold on request
    // -----------------------------------------------------------------------
    initial
    begin : drain_pattern
        int seg_left;
        int mode;
        int period;
        int phase;
        seg_left = 0;
        mode     = 0;
        period   = 2;
        phase    = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done < holds_wanted)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_done++;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(20, 150);
                    period   = $urandom_range(2, 5);
                end
                seg_left--;
                phase++;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (phase % period == 0);
                endcase
            end
        end
    end

    // result monitor: each taken result beat against the oldest prediction
    always @(posedge clk)
    begin : check_results
        udlf_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_outputs.size() == 0)
                report_mismatch("unexpected result beat", 8'h00, 8'h00);
            else
            begin
                want = predicted_outputs.pop_front();
                if (tx_valid !== want.tx_valid)
                    report_mismatch("tx_valid", tx_valid, want.tx_valid);
                if (tx_byte !== want.tx_byte)
                    report_mismatch("tx_byte", tx_byte, want.tx_byte);
                if (read_data !== want.read_data)
                    report_mismatch("read_data", read_data, want.read_data);
                if (message_ready !== want.message_ready)
                    report_mismatch("message_ready", message_ready, want.message_ready);
                if (line_length !== want.line_length)
                    report_mismatch("line_length", line_length, want.line_length);
                if (receive_enabled !== want.receive_enabled)
                    report_mismatch("receive_enabled", receive_enabled,
                                    want.receive_enabled);
                if (end_wait !== want.end_wait)
                    report_mismatch("end_wait", end_wait, want.end_wait);
            end
        end
    end

    // -----------------------------------------------------------------------
    // main sequence
    // -----------------------------------------------------------------------
    initial
    begin : main_sequence
        int guard;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        req_type   <= '0;
        rx_byte    <= '0;
        host_index <= '0;
        host_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frame();
        test_overflow();
        test_transmit_wrap();
        test_backpressure();
        test_random_traffic();

        in_valid <= 1'b0;
        for (guard = 0; guard < DRAIN_LIMIT && predicted_outputs.size() != 0; guard++)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (predicted_outputs.size() != 0)
            report_mismatch("result beats never delivered",
                            8'(predicted_outputs.size()), 8'h00);

        if (mismatches == 0)
            $display("** uart_dollar_line_framer: PASSED **");
        else
            $display("** uart_dollar_line_framer: FAILED **");
        $finish;
    end

    // watchdog for a hung handshake
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("** uart_dollar_line_framer: FAILED **");
        $finish;
    end

endmodule

FILE: uart_dollar_line_framer.f
+incdir+src
src/udlf_pkg.sv
src/udlf_line_ram.sv
src/udlf_exec.sv
src/uart_dollar_line_framer.sv
tb/sv/uart_dollar_line_framer_tb.sv
